// ===== design/five_button_analog_pad_scanner_defines.svh =====
// assertion macros for the five-button pad scanner
`ifndef FIVE_BUTTON_ANALOG_PAD_SCANNER_DEFINES_SVH
`define FIVE_BUTTON_ANALOG_PAD_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every rising edge, held off while reset is asserted
`define FBAPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every rising edge, reset included
`define FBAPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBAPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FBAPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/fbaps_pkg.sv =====
// package: types and constants of the five-button pad scanner
`timescale 1ns / 1ps

package fbaps_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int LEVEL_W     = 8;
    localparam int CODE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // stream widths
    localparam int IN_TDATA_W  = 24;  // 17 bits of fields, padded to bytes
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;  // 47 bits of fields, padded to bytes
    localparam int OUT_TUSER_W = 2;

    // register reset values
    localparam logic [LEVEL_W-1:0] RST_STRONG_THRESHOLD = 8'd30;
    localparam logic [LEVEL_W-1:0] RST_WEAK_THRESHOLD   = 8'd200;
    localparam logic [7:0]         RST_LOCKOUT_TICKS    = 8'd5;
    localparam logic [CODE_W-1:0]  RST_FIRST_KEY_CODE   = 8'd30;

    typedef enum logic [1:0] {
        ACT_SCAN   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_REPORT = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRONG_THRESHOLD = 2'd0,
        CFG_WEAK_THRESHOLD   = 2'd1,
        CFG_LOCKOUT_TICKS    = 2'd2,
        CFG_FIRST_KEY_CODE   = 2'd3
    } t_cfg_reg;

endpackage

// ===== design/five_button_analog_pad_scanner.sv =====
// top level: five-button analog pad scanner
//
//  channel   | direction | transfer carries
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | one item: action, middle button, pair levels
//  m_axis    | out       | one result per item: slots, flags, pressed mask
//  cfg       | in        | register write: index and data, always ready
//
//  one item is taken per cycle while s_axis_tready is high; its result sits in
//  the output register in the cycle after the transfer
//  there is a single state/result register stage: decode, exclusion and flag
//  updates run combinationally on the stored state
//  s_axis_tready is high while the output register is empty or being drained
//  i_rst_n is synchronous and active low; there is no clearing pass
//  a stall on m_axis holds the result and stops intake in the same cycle
`timescale 1ns / 1ps

`include "five_button_analog_pad_scanner_defines.svh"

module five_button_analog_pad_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] middle_pressed_raw, [8:1] pair_a_level, [16:9] pair_b_level, rest zero
    input  logic [fbaps_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] action
    input  logic [fbaps_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] slot_one, [15:8] slot_two, [23:16] slot_three, [31:24] slot_four,
    // [39:32] slot_five, [40] report_needed, [41] lockout_active,
    // [46:42] pressed_mask, [47] zero
    output logic [fbaps_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] is_report, [1] rebuilt
    output logic [fbaps_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fbaps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbaps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fbaps_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0]     r_strong_threshold;
    logic [LEVEL_W-1:0]     r_weak_threshold;
    logic [7:0]             r_lockout_ticks;
    logic [CODE_W-1:0]      r_first_key_code;

    // pad state: a button level is 0/1 once scanned; before the first scan
    // every stored level reads as nonzero (tracked by r_unscanned)
    logic [NUM_BUTTONS-1:0] r_level,    n_level;
    logic                   r_unscanned, n_unscanned;
    logic [NUM_BUTTONS-1:0] r_change,   n_change;
    logic [CODE_W-1:0]      r_slot [NUM_BUTTONS];
    logic [CODE_W-1:0]      n_slot [NUM_BUTTONS];
    logic                   r_needs_report, n_needs_report;
    logic                   r_lockout,      n_lockout;
    logic [7:0]             r_tick_count,   n_tick_count;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [OUT_TUSER_W-1:0] r_out_tuser, n_out_tuser;

    logic                   in_xfer;
    logic                   cfg_xfer;
    t_action                action;
    logic                   mid_raw;
    logic [LEVEL_W-1:0]     lev_a;
    logic [LEVEL_W-1:0]     lev_b;
    logic [NUM_BUTTONS-1:0] stored_nz;   // stored level nonzero
    logic [NUM_BUTTONS-1:0] nv;          // freshly decoded levels
    logic [NUM_BUTTONS-1:0] diff;
    logic [7:0]             tick_inc;
    logic                   is_report;
    logic                   rebuilt;

    // output register drains or is empty: room for the next item
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_xfer      = i_cfg_valid && o_cfg_ready;

    assign action  = t_action'(s_axis_tuser);
    assign mid_raw = s_axis_tdata[0];
    assign lev_a   = s_axis_tdata[8:1];
    assign lev_b   = s_axis_tdata[16:9];

    assign stored_nz = r_level | {NUM_BUTTONS{r_unscanned}};
    assign tick_inc  = r_tick_count + 8'd1;

    // scan decode with exclusion against the stored levels
    always_comb begin
        nv = '0;
        if (!stored_nz[0]) begin
            // middle not held: read both analog pairs
            nv[1] = lev_a < r_strong_threshold;
            nv[2] = !nv[1] && (lev_a < r_weak_threshold);
            nv[3] = lev_b < r_strong_threshold;
            nv[4] = !nv[3] && (lev_b < r_weak_threshold);
            // any direction drops the middle button
            nv[0] = mid_raw && !(|nv[4:1]);
        end else begin
            nv[0] = mid_raw;
        end
        nv[0] = nv[0] && !(|stored_nz[4:1]);
        nv[1] = nv[1] && !stored_nz[2];
        nv[2] = nv[2] && !stored_nz[1];
        nv[3] = nv[3] && !stored_nz[4];
        nv[4] = nv[4] && !stored_nz[3];
        // before the first scan every button counts as changed
        diff = r_unscanned ? {NUM_BUTTONS{1'b1}} : (nv ^ r_level);
    end

    // next state and result for the accepted item
    always_comb begin
        n_level        = r_level;
        n_unscanned    = r_unscanned;
        n_change       = r_change;
        n_slot         = r_slot;
        n_needs_report = r_needs_report;
        n_lockout      = r_lockout;
        n_tick_count   = r_tick_count;
        is_report      = 1'b0;
        rebuilt        = 1'b0;

        unique case (action)
            ACT_SCAN: begin
                if (!r_lockout) begin
                    n_level     = nv;
                    n_unscanned = 1'b0;
                    n_change    = r_change | diff;
                    if (|diff) begin
                        n_lockout      = 1'b1;
                        n_needs_report = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                if (r_lockout) begin
                    // compare covers a limit lowered mid-lockout and a zero limit
                    if (tick_inc >= r_lockout_ticks) begin
                        n_tick_count = '0;
                        n_lockout    = 1'b0;
                    end else begin
                        n_tick_count = tick_inc;
                    end
                end
            end
            ACT_REPORT: begin
                is_report = 1'b1;
                if (r_needs_report) begin
                    rebuilt = 1'b1;
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        if (r_change[i]) begin
                            n_slot[i] = stored_nz[i]
                                      ? r_first_key_code + CODE_W'(i) : '0;
                        end
                    end
                    n_change       = '0;
                    n_needs_report = 1'b0;
                end
            end
            default: begin
                // unused action code: state untouched
            end
        endcase

        n_out_tuser = {rebuilt, is_report};
        n_out_tdata = {1'b0,
                       n_level | {NUM_BUTTONS{n_unscanned}},
                       n_lockout,
                       n_needs_report,
                       n_slot[4], n_slot[3], n_slot[2], n_slot[1], n_slot[0]};
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strong_threshold <= RST_STRONG_THRESHOLD;
            r_weak_threshold   <= RST_WEAK_THRESHOLD;
            r_lockout_ticks    <= RST_LOCKOUT_TICKS;
            r_first_key_code   <= RST_FIRST_KEY_CODE;
        end else if (cfg_xfer) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_STRONG_THRESHOLD: r_strong_threshold <= i_cfg_data;
                CFG_WEAK_THRESHOLD:   r_weak_threshold   <= i_cfg_data;
                CFG_LOCKOUT_TICKS:    r_lockout_ticks    <= i_cfg_data;
                CFG_FIRST_KEY_CODE:   r_first_key_code   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pad state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= '0;
            r_unscanned    <= 1'b1;
            r_change       <= '0;
            r_needs_report <= 1'b1;
            r_lockout      <= 1'b0;
            r_tick_count   <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (in_xfer) begin
            r_level        <= n_level;
            r_unscanned    <= n_unscanned;
            r_change       <= n_change;
            r_needs_report <= n_needs_report;
            r_lockout      <= n_lockout;
            r_tick_count   <= n_tick_count;
            r_slot         <= n_slot;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // the tick counter only runs inside a lockout
    `FBAPS_ASSERT(a_tick_in_lockout, i_clk, i_rst_n,
        (r_tick_count != 8'd0) |-> r_lockout,
        "tick count nonzero outside lockout")
    // a scan taken during lockout leaves the button levels alone
    `FBAPS_ASSERT(a_lockout_holds_levels, i_clk, i_rst_n,
        (in_xfer && action == ACT_SCAN && r_lockout) |=> $stable(r_level),
        "scan during lockout changed button levels")
    // a scan that changes any button starts the lockout
    `FBAPS_ASSERT(a_change_starts_lockout, i_clk, i_rst_n,
        (in_xfer && action == ACT_SCAN && !r_lockout && (diff != '0)) |=> r_lockout,
        "button change did not start lockout")
    // a rebuilt report always leaves no report pending
    `FBAPS_ASSERT(a_rebuilt_clears_need, i_clk, i_rst_n,
        (r_out_valid && r_out_tuser[1]) |-> (r_out_tuser[0] && !r_out_tdata[40]),
        "rebuilt report left a report pending")

endmodule
